// File: rtl/salru_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// salru_pkg
// Shared types and codes for the set-associative LRU cache tag-store model.
// ----------------------------------------------------------------------------
package salru_pkg;

   // Request beat
   typedef struct packed {
      logic        is_write;
      logic [31:0] address;
   } req_type;

   // Response beat
   typedef struct packed {
      logic [1:0]  outcome;
      logic [9:0]  set_index;
      logic [31:0] tag_value;
      logic [2:0]  way_used;
      logic [31:0] prior_tag;
      logic        prior_tag_known;
      logic        prior_valid;
      logic        prior_dirty;
      logic [31:0] prior_stamp;
      logic [31:0] access_index;
      logic [16:0] access_cost;
   } rsp_type;

   // One line of the tag store
   typedef struct packed {
      logic        valid;
      logic        dirty;
      logic [31:0] tag;
      logic [31:0] stamp;
   } line_type;

   // Outcome codes
   localparam logic [1:0] OUT_HIT   = 2'd0;
   localparam logic [1:0] OUT_CLEAN = 2'd1;
   localparam logic [1:0] OUT_DIRTY = 2'd2;

   // CSR indexes
   localparam logic [1:0] CSR_OFFSET_BITS  = 2'd0;
   localparam logic [1:0] CSR_SET_BITS     = 2'd1;
   localparam logic [1:0] CSR_WAYS_IN_USE  = 2'd2;
   localparam logic [1:0] CSR_MISS_PENALTY = 2'd3;

   // Reset values of the CSRs
   localparam logic [4:0]  RST_OFFSET_BITS  = 5'd5;
   localparam logic [3:0]  RST_SET_BITS     = 4'd6;
   localparam logic [3:0]  RST_WAYS_IN_USE  = 4'd4;
   localparam logic [15:0] RST_MISS_PENALTY = 16'd100;

   // Largest offset and set field the address split honors
   localparam logic [4:0] OFFSET_BITS_MAX = 5'd16;
   localparam logic [3:0] SET_BITS_MAX    = 4'd10;

endpackage
`default_nettype wire

// File: rtl/set_assoc_cache_lru_model.sv
`timescale 1ns / 1ps
`default_nettype none
// A request is registered, then the sequencer scans 1..ways_in_use ways of its set
// and registers the response beat; the scan stops at the first hit or free way.
// A new request is taken only when the sequencer is idle, as the single read port
// of the line store is read once per way; a held response adds stalls.
// Reset: CSRs return to 5/6/4/100, the access counter to zero, and a clearing
// pass over all MAX_SETS*MAX_WAYS lines (8192 by default) zeroes the line store.
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_model
// Tag-store model of a write-back, write-allocate set-associative cache with
// LRU replacement: CSRs, address split, line store and way-scan sequencer.
// ----------------------------------------------------------------------------
module set_assoc_cache_lru_model
   import salru_pkg::*;
#(
   parameter int MAX_SETS   = 1024,
   parameter int MAX_WAYS   = 8,
   parameter int ADDR_WIDTH = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire req_type     req_data,
   // response channel
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output rsp_type          rsp_data,
   // CSR write port
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

   localparam int LINES  = MAX_SETS * MAX_WAYS;
   localparam int LINE_W = (LINES > 1) ? $clog2(LINES) : 1;
   localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
   localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   // largest set field whose set count fits MAX_SETS
   localparam int SB_FIT = $clog2(MAX_SETS + 1) - 1;
   localparam logic [3:0] SB_LIM =
      (SB_FIT < 10) ? 4'(SB_FIT) : SET_BITS_MAX;
   localparam logic [5:0] WAYS_MAX = 6'(MAX_WAYS);
   localparam logic [31:0] ADDR_MASK =
      (ADDR_WIDTH >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << ADDR_WIDTH) - 64'd1);

   logic [4:0]  offset_bits_ff, offset_bits_in;
   logic [3:0]  set_bits_ff, set_bits_in;
   logic [3:0]  ways_in_use_ff, ways_in_use_in;
   logic [15:0] miss_penalty_ff, miss_penalty_in;

   // CSR writes
   always_comb begin
      offset_bits_in  = offset_bits_ff;
      set_bits_in     = set_bits_ff;
      ways_in_use_in  = ways_in_use_ff;
      miss_penalty_in = miss_penalty_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_OFFSET_BITS:  offset_bits_in  = csr_wdata[4:0];
            CSR_SET_BITS:     set_bits_in     = csr_wdata[3:0];
            CSR_WAYS_IN_USE:  ways_in_use_in  = csr_wdata[3:0];
            CSR_MISS_PENALTY: miss_penalty_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_bits_ff  <= RST_OFFSET_BITS;
         set_bits_ff     <= RST_SET_BITS;
         ways_in_use_ff  <= RST_WAYS_IN_USE;
         miss_penalty_ff <= RST_MISS_PENALTY;
      end else begin
         offset_bits_ff  <= offset_bits_in;
         set_bits_ff     <= set_bits_in;
         ways_in_use_ff  <= ways_in_use_in;
         miss_penalty_ff <= miss_penalty_in;
      end
   end

   // clamp the CSRs to what the store supports
   logic [4:0]       ob;
   logic [3:0]       sb;
   logic [5:0]       nw;
   logic [WAY_W-1:0] last_way;

   assign ob = (offset_bits_ff > OFFSET_BITS_MAX) ? OFFSET_BITS_MAX : offset_bits_ff;
   assign sb = (set_bits_ff > SB_LIM) ? SB_LIM : set_bits_ff;

   always_comb begin
      nw = {2'b00, ways_in_use_ff};
      if (nw == 6'd0) begin
         nw = 6'd1;
      end
      if (nw > WAYS_MAX) begin
         nw = WAYS_MAX;
      end
   end

   assign last_way = WAY_W'(nw - 6'd1);

   // address split into set and tag
   logic [31:0]      addr_m;
   logic [31:0]      set_full;
   logic [31:0]      tag;
   logic [5:0]       tag_shift;
   logic [SET_W-1:0] set_idx;

   assign addr_m    = req_data.address & ADDR_MASK;
   assign set_full  = (addr_m >> ob) & ((32'd1 << sb) - 32'd1);
   assign tag_shift = {1'b0, ob} + {2'b00, sb};
   assign tag       = addr_m >> tag_shift;
   assign set_idx   = SET_W'(set_full);

   // line store and sequencer
   logic              store_busy;
   logic              scan_idle;
   logic              start;
   logic              rd_en, wr_en;
   logic [LINE_W-1:0] rd_addr, wr_addr;
   line_type          rd_data, wr_data;

   assign req_ready = scan_idle && !store_busy;
   assign start     = req_valid && req_ready;

   salru_line_store #(
      .LINES  (LINES),
      .LINE_W (LINE_W)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .busy    (store_busy)
   );

   salru_scan #(
      .MAX_WAYS (MAX_WAYS),
      .SET_W    (SET_W),
      .WAY_W    (WAY_W),
      .LINE_W   (LINE_W)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .is_write  (req_data.is_write),
      .set_idx   (set_idx),
      .tag       (tag),
      .last_way  (last_way),
      .penalty   (miss_penalty_ff),
      .idle      (scan_idle),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

// File: rtl/salru_line_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// salru_line_store
// Line memory (valid, dirty, tag, stamp) with one write and one registered
// read port, plus a clearing pass after reset that zeroes every line.
// ----------------------------------------------------------------------------
module salru_line_store
   import salru_pkg::*;
#(
   parameter int LINES  = 8192,
   parameter int LINE_W = 13
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              wr_en,
   input  wire logic [LINE_W-1:0] wr_addr,
   input  wire line_type          wr_data,
   input  wire logic              rd_en,
   input  wire logic [LINE_W-1:0] rd_addr,
   output line_type               rd_data,
   output logic                   busy
);

   localparam logic [LINE_W-1:0] LAST_LINE = LINE_W'(LINES - 1);

   line_type          mem [LINES];
   line_type          rd_data_ff;
   logic [LINE_W-1:0] clr_addr_ff, clr_addr_in;
   logic              clr_busy_ff, clr_busy_in;

   // clearing pass sweep
   always_comb begin
      clr_addr_in = clr_addr_ff;
      clr_busy_in = clr_busy_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == LAST_LINE) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
         clr_busy_ff <= 1'b1;
      end else begin
         clr_addr_ff <= clr_addr_in;
         clr_busy_ff <= clr_busy_in;
      end
   end

   // memory array: clear pass has the write port while busy
   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         mem[clr_addr_ff] <= '0;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign busy    = clr_busy_ff;

endmodule
`default_nettype wire

// File: rtl/salru_scan.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// salru_scan
// Sequencer that walks the ways of one set through a single compare unit
// (tag match and stamp compare), picks hit, free way or LRU victim, writes
// the line back and holds the response beat.
// ----------------------------------------------------------------------------
module salru_scan
   import salru_pkg::*;
#(
   parameter int MAX_WAYS = 8,
   parameter int SET_W    = 10,
   parameter int WAY_W    = 3,
   parameter int LINE_W   = 13
) (
   input  wire logic              clock,
   input  wire logic              reset,
   // item start
   input  wire logic              start,
   input  wire logic              is_write,
   input  wire logic [SET_W-1:0]  set_idx,
   input  wire logic [31:0]       tag,
   input  wire logic [WAY_W-1:0]  last_way,
   input  wire logic [15:0]       penalty,
   output logic                   idle,
   // line store
   output logic                   rd_en,
   output logic [LINE_W-1:0]      rd_addr,
   input  wire line_type          rd_data,
   output logic                   wr_en,
   output logic [LINE_W-1:0]      wr_addr,
   output line_type               wr_data,
   // response
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output rsp_type                rsp_data
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_FIRST = 2'd1;
   localparam logic [1:0] ST_SCAN  = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   localparam logic [1:0] KIND_HIT   = 2'd0;
   localparam logic [1:0] KIND_FILL  = 2'd1;
   localparam logic [1:0] KIND_EVICT = 2'd2;

   localparam logic [LINE_W-1:0] WAYS_L = LINE_W'(MAX_WAYS);

   logic [1:0]        state_ff, state_in;
   logic              wr_ff, wr_in;
   logic [SET_W-1:0]  set_ff, set_in;
   logic [31:0]       tag_ff, tag_in;
   logic [WAY_W-1:0]  last_ff, last_in;
   logic [15:0]       pen_ff, pen_in;
   logic [WAY_W-1:0]  chk_ff, chk_in;
   line_type          best_ff, best_in;
   logic [WAY_W-1:0]  best_way_ff, best_way_in;
   line_type          sel_ff, sel_in;
   logic [WAY_W-1:0]  sel_way_ff, sel_way_in;
   logic [1:0]        kind_ff, kind_in;
   logic [31:0]       count_ff, count_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic [LINE_W-1:0] base;
   logic [WAY_W-1:0]  rd_way;
   logic              hit, older, commit;
   logic [16:0]       pen17;

   assign base  = LINE_W'(set_ff) * WAYS_L;
   assign hit   = rd_data.valid && (rd_data.tag == tag_ff);
   assign older = (chk_ff == '0) || (rd_data.stamp < best_ff.stamp);
   assign pen17 = {1'b0, pen_ff};

   // sequencer
   always_comb begin
      state_in     = state_ff;
      wr_in        = wr_ff;
      set_in       = set_ff;
      tag_in       = tag_ff;
      last_in      = last_ff;
      pen_in       = pen_ff;
      chk_in       = chk_ff;
      best_in      = best_ff;
      best_way_in  = best_way_ff;
      sel_in       = sel_ff;
      sel_way_in   = sel_way_ff;
      kind_in      = kind_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      rd_en        = 1'b0;
      rd_way       = '0;
      wr_en        = 1'b0;
      wr_data      = '0;
      commit       = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               wr_in    = is_write;
               set_in   = set_idx;
               tag_in   = tag;
               last_in  = last_way;
               pen_in   = penalty;
               state_in = ST_FIRST;
            end
         end
         ST_FIRST: begin
            // fetch way 0
            rd_en    = 1'b1;
            rd_way   = '0;
            chk_in   = '0;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            // prefetch the next way while checking this one
            rd_way = chk_ff + 1'b1;
            rd_en  = (chk_ff != last_ff);
            if (!rd_data.valid) begin
               sel_in     = rd_data;
               sel_way_in = chk_ff;
               kind_in    = KIND_FILL;
               state_in   = ST_DONE;
            end else if (hit) begin
               sel_in     = rd_data;
               sel_way_in = chk_ff;
               kind_in    = KIND_HIT;
               state_in   = ST_DONE;
            end else if (chk_ff == last_ff) begin
               // LRU victim, lowest way wins a tie
               sel_in     = older ? rd_data : best_ff;
               sel_way_in = older ? chk_ff : best_way_ff;
               kind_in    = KIND_EVICT;
               state_in   = ST_DONE;
            end else begin
               if (older) begin
                  best_in     = rd_data;
                  best_way_in = chk_ff;
               end
               chk_in = chk_ff + 1'b1;
            end
         end
         ST_DONE: begin
            commit = !rsp_valid_ff || rsp_ready;
            if (commit) begin
               // write the used line back
               wr_en         = 1'b1;
               wr_data.valid = 1'b1;
               wr_data.dirty = (kind_ff == KIND_HIT) ? (sel_ff.dirty | wr_ff) : wr_ff;
               wr_data.tag   = tag_ff;
               wr_data.stamp = count_ff;

               rsp_in.set_index    = 10'(set_ff);
               rsp_in.tag_value    = tag_ff;
               rsp_in.way_used     = 3'(sel_way_ff);
               rsp_in.prior_stamp  = sel_ff.stamp;
               rsp_in.access_index = count_ff;
               case (kind_ff)
                  KIND_HIT: begin
                     rsp_in.outcome         = OUT_HIT;
                     rsp_in.prior_tag       = tag_ff;
                     rsp_in.prior_tag_known = 1'b1;
                     rsp_in.prior_valid     = 1'b1;
                     rsp_in.prior_dirty     = sel_ff.dirty;
                     rsp_in.access_cost     = 17'd1;
                  end
                  KIND_FILL: begin
                     rsp_in.outcome         = OUT_CLEAN;
                     rsp_in.prior_tag       = '0;
                     rsp_in.prior_tag_known = 1'b0;
                     rsp_in.prior_valid     = 1'b0;
                     rsp_in.prior_dirty     = 1'b0;
                     rsp_in.access_cost     = 17'd1 + pen17;
                  end
                  default: begin
                     rsp_in.outcome         = sel_ff.dirty ? OUT_DIRTY : OUT_CLEAN;
                     rsp_in.prior_tag       = sel_ff.tag;
                     rsp_in.prior_tag_known = 1'b1;
                     rsp_in.prior_valid     = 1'b1;
                     rsp_in.prior_dirty     = sel_ff.dirty;
                     rsp_in.access_cost     = sel_ff.dirty ? (17'd1 + {pen_ff, 1'b0})
                                                           : (17'd1 + pen17);
                  end
               endcase
               rsp_valid_in = 1'b1;
               count_in     = count_ff + 32'd1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      wr_ff       <= wr_in;
      set_ff      <= set_in;
      tag_ff      <= tag_in;
      last_ff     <= last_in;
      pen_ff      <= pen_in;
      chk_ff      <= chk_in;
      best_ff     <= best_in;
      best_way_ff <= best_way_in;
      sel_ff      <= sel_in;
      sel_way_ff  <= sel_way_in;
      kind_ff     <= kind_in;
      rsp_ff      <= rsp_in;
   end

   assign rd_addr   = base + LINE_W'(rd_way);
   assign wr_addr   = base + LINE_W'(sel_way_ff);
   assign idle      = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

// File: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the set-associative LRU cache tag-store model.
// A directed table (reset state, field extremes, clamped registers, dirty
// write-back) runs first. It is followed by phases of random accesses drawn
// from small set and tag pools, so that hits, fills, clean and dirty
// evictions all occur. Each phase runs under random register settings. A
// line-level model of the tag store predicts every response beat.
// ----------------------------------------------------------------------------
module tb;
   import salru_pkg::*;

   localparam int LINE_WAYS     = 8;
   localparam int LINE_COUNT    = 1024 * LINE_WAYS;
   localparam int N_PHASES      = 8;
   localparam int PHASE_ACCESSES = 195;
   localparam int HOLD_AT       = 300;   // request beats seen before the long stall
   localparam int HOLD_CYCLES   = 400;
   localparam int TAIL_CYCLES   = 24;
   localparam int MAX_PRINTS    = 100;

   // DUT connections
   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_data;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [15:0] csr_wdata;

   set_assoc_cache_lru_model u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Shadow tag store and registers
   bit          line_valid [LINE_COUNT];
   bit          line_dirty [LINE_COUNT];
   bit [31:0]   tag_mem    [LINE_COUNT];
   bit [31:0]   line_stamp [LINE_COUNT];
   bit [31:0]   access_seq = '0;
   logic [4:0]  cfg_offset  = RST_OFFSET_BITS;
   logic [3:0]  cfg_sets    = RST_SET_BITS;
   logic [3:0]  cfg_ways    = RST_WAYS_IN_USE;
   logic [15:0] cfg_penalty = RST_MISS_PENALTY;

   // Responses still owed by the block, oldest first
   rsp_type     owed_rsp [$];

   int          req_beats = 0;
   int          rsp_beats = 0;
   int          rsp_idle_pct = 20;
   int          n_errors = 0;
   int          n_settings = 1;
   int          outcome_tally [3] = '{0, 0, 0};

   // Directed table
   typedef struct {
      bit          is_csr;
      logic [1:0]  csr_idx;
      logic [15:0] csr_val;
      req_type     beat;
      bit          typed;
      rsp_type     want;
   } dir_row;

   dir_row      dir_rows [$];

   // Clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Watchdog
   initial begin
      #2_000_000;
      $display("timeout: response stream stopped");
      $display("set_assoc_cache_lru_model: mismatch");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      if (n_errors < MAX_PRINTS) $display("ERROR @%0t: %s", $realtime, msg);
      n_errors++;
   endtask

   task automatic check_field(input string name, input int idx,
                              input logic [31:0] got, input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("access %0d %s: got %0h, expected %0h",
                                   idx, name, got, want));
   endtask

   // Effective register values after clamping
   function automatic void eff_cfg(output int ob, output int sb, output int nw);
      ob = (cfg_offset > OFFSET_BITS_MAX) ? int'(OFFSET_BITS_MAX) : int'(cfg_offset);
      sb = (cfg_sets > SET_BITS_MAX) ? int'(SET_BITS_MAX) : int'(cfg_sets);
      nw = (cfg_ways == 0) ? 1 : (cfg_ways > LINE_WAYS) ? LINE_WAYS : int'(cfg_ways);
   endfunction

   // Tag-store lookup and update for one access
   function automatic rsp_type predict_access(input req_type beat);
      rsp_type     r;
      int          ob, sb, nw, base, way, k;
      bit          found;
      logic [63:0] wide, t;
      eff_cfg(ob, sb, nw);
      wide = {32'd0, beat.address};
      r = '0;
      t = (wide >> ob) & ((64'd1 << sb) - 64'd1);
      r.set_index = t[9:0];
      t = wide >> (ob + sb);
      r.tag_value = t[31:0];
      base = LINE_WAYS * r.set_index;
      r.outcome = OUT_CLEAN;
      r.access_cost = 17'd1 + {1'b0, cfg_penalty};
      way = 0;
      found = 1'b0;
      // search: hit on a valid matching way, fill on the first invalid way
      for (k = 0; k < nw && !found; k++) begin
         if (line_valid[base + k]) begin
            if (tag_mem[base + k] == r.tag_value) begin
               way = k;
               found = 1'b1;
               r.outcome = OUT_HIT;
               r.access_cost = 17'd1;
               r.prior_tag = r.tag_value;
               r.prior_tag_known = 1'b1;
               r.prior_valid = 1'b1;
               r.prior_dirty = line_dirty[base + k];
               if (beat.is_write) line_dirty[base + k] = 1'b1;
            end
         end else begin
            way = k;
            found = 1'b1;
            line_valid[base + k] = 1'b1;
            tag_mem[base + k] = r.tag_value;
            line_dirty[base + k] = beat.is_write;
         end
      end
      // no hit, no free way: oldest stamp goes, ties to the lowest way
      if (!found) begin
         for (k = 1; k < nw; k++)
            if (line_stamp[base + k] < line_stamp[base + way]) way = k;
         r.prior_tag = tag_mem[base + way];
         r.prior_tag_known = 1'b1;
         r.prior_valid = 1'b1;
         r.prior_dirty = line_dirty[base + way];
         if (r.prior_dirty) begin
            r.outcome = OUT_DIRTY;
            r.access_cost = 17'd1 + {cfg_penalty, 1'b0};
         end
         tag_mem[base + way] = r.tag_value;
         line_dirty[base + way] = beat.is_write;
      end
      r.way_used = way[2:0];
      r.prior_stamp = line_stamp[base + way];
      r.access_index = access_seq;
      line_stamp[base + way] = access_seq;
      access_seq = access_seq + 32'd1;
      return r;
   endfunction

   // Table builders
   function automatic void add_access(input logic wr, input logic [31:0] addr);
      dir_row row;
      row = '{default: '0};
      row.beat = '{is_write: wr, address: addr};
      dir_rows.push_back(row);
   endfunction

   function automatic void add_checked(input logic wr, input logic [31:0] addr,
                                       input rsp_type want);
      dir_row row;
      row = '{default: '0};
      row.beat = '{is_write: wr, address: addr};
      row.typed = 1'b1;
      row.want = want;
      dir_rows.push_back(row);
   endfunction

   function automatic void add_csr(input logic [1:0] idx, input logic [15:0] val);
      dir_row row;
      row = '{default: '0};
      row.is_csr = 1'b1;
      row.csr_idx = idx;
      row.csr_val = val;
      dir_rows.push_back(row);
   endfunction

   // Offer one request beat and hold it until accepted; valid stays high
   task automatic send_access(input req_type beat, input bit typed, input rsp_type want);
      rsp_type model;
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (!req_ready);
      model = predict_access(beat);
      owed_rsp.push_back(typed ? want : model);
      req_beats <= req_beats + 1;
   endtask

   // Random idle burst on the request side
   task automatic maybe_idle(input int pct);
      if ($urandom_range(99) < pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   endtask

   // Stop offering and wait until every accepted beat has been answered
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (req_beats != rsp_beats);
   endtask

   // Register write; leaves csr_we high so writes can go back to back
   task automatic csr_write(input logic [1:0] idx, input logic [15:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         CSR_OFFSET_BITS:  cfg_offset  = value[4:0];
         CSR_SET_BITS:     cfg_sets    = value[3:0];
         CSR_WAYS_IN_USE:  cfg_ways    = value[3:0];
         CSR_MISS_PENALTY: cfg_penalty = value;
         default: ;
      endcase
   endtask

   // Response side: checking, random stalls and one long hold-off
   initial begin : response_side
      rsp_type want;
      int      burst_left;
      int      hold_left;
      bit      held;
      logic    next_ready;
      burst_left = 0;
      hold_left  = 0;
      held       = 1'b0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            if (owed_rsp.size() == 0) begin
               report_mismatch("response beat with no access outstanding");
            end else begin
               want = owed_rsp.pop_front();
               check_field("outcome", want.access_index, rsp_data.outcome, want.outcome);
               check_field("set_index", want.access_index, rsp_data.set_index,
                           want.set_index);
               check_field("tag_value", want.access_index, rsp_data.tag_value,
                           want.tag_value);
               check_field("way_used", want.access_index, rsp_data.way_used,
                           want.way_used);
               check_field("prior_tag", want.access_index, rsp_data.prior_tag,
                           want.prior_tag);
               check_field("prior_tag_known", want.access_index,
                           rsp_data.prior_tag_known, want.prior_tag_known);
               check_field("prior_valid", want.access_index, rsp_data.prior_valid,
                           want.prior_valid);
               check_field("prior_dirty", want.access_index, rsp_data.prior_dirty,
                           want.prior_dirty);
               check_field("prior_stamp", want.access_index, rsp_data.prior_stamp,
                           want.prior_stamp);
               check_field("access_index", want.access_index, rsp_data.access_index,
                           want.access_index);
               check_field("access_cost", want.access_index, rsp_data.access_cost,
                           want.access_cost);
               if (want.outcome <= OUT_DIRTY) outcome_tally[want.outcome]++;
            end
            rsp_beats <= rsp_beats + 1;
         end
         // long stall once, so the block backs up into the request channel
         if (!held && req_beats >= HOLD_AT) begin
            held = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            next_ready = 1'b0;
         end else if (burst_left > 0) begin
            burst_left--;
            next_ready = 1'b0;
         end else if ($urandom_range(99) < rsp_idle_pct) begin
            burst_left = $urandom_range(1, 16) - 1;
            next_ready = 1'b0;
         end else begin
            next_ready = 1'b1;
         end
         rsp_ready <= next_ready;
      end
   end

   // Request side: reset, directed table, random phases, wrap-up
   initial begin : request_side
      dir_row      row;
      bit          in_csr;
      int          ph, i, ob, sb, nw, n_tags, n_sets, idle_pct;
      logic [15:0] wd;
      logic [31:0] pool_tag [12];
      logic [9:0]  pool_set [4];
      logic [31:0] rnd;
      logic [63:0] wide;
      req_type     beat;

      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_we    <= 1'b0;
      csr_index <= CSR_OFFSET_BITS;
      csr_wdata <= '0;

      // reset-state accesses with defaults (64 sets, 4 ways, penalty 100)
      add_checked(1'b0, 32'h0000_0000,
                  {OUT_CLEAN, 10'd0, 32'd0, 3'd0, 32'd0, 1'b0, 1'b0, 1'b0,
                   32'd0, 32'd0, 17'd101});
      add_checked(1'b1, 32'h0000_001F,
                  {OUT_HIT, 10'd0, 32'd0, 3'd0, 32'd0, 1'b1, 1'b1, 1'b0,
                   32'd0, 32'd1, 17'd1});
      add_checked(1'b0, 32'hFFFF_FFFF,
                  {OUT_CLEAN, 10'd63, 32'h001F_FFFF, 3'd0, 32'd0, 1'b0, 1'b0, 1'b0,
                   32'd0, 32'd2, 17'd101});
      add_access(1'b1, 32'h0000_0800);
      add_access(1'b0, 32'h0000_1000);
      add_access(1'b0, 32'h0000_1800);
      // set 0 full: oldest line is the dirty one in way 0
      add_checked(1'b0, 32'h0000_2000,
                  {OUT_DIRTY, 10'd0, 32'd4, 3'd0, 32'd0, 1'b1, 1'b1, 1'b1,
                   32'd1, 32'd6, 17'd201});
      add_access(1'b0, 32'h0000_0800);
      add_access(1'b1, 32'h0000_3000);
      // registers out of range or at the top: offset 16, set bits 10, one way, top penalty
      add_csr(CSR_OFFSET_BITS, 16'hFFFF);
      add_csr(CSR_SET_BITS, 16'hFFFF);
      add_csr(CSR_WAYS_IN_USE, 16'hFFF0);
      add_csr(CSR_MISS_PENALTY, 16'hFFFF);
      add_checked(1'b0, 32'hFFFF_FFFF,
                  {OUT_CLEAN, 10'd1023, 32'd63, 3'd0, 32'd0, 1'b0, 1'b0, 1'b0,
                   32'd0, 32'd9, 17'd65536});
      add_access(1'b1, 32'hFFFF_0000);
      add_checked(1'b0, 32'h0FFF_0000,
                  {OUT_DIRTY, 10'd1023, 32'd3, 3'd0, 32'd63, 1'b1, 1'b1, 1'b1,
                   32'd10, 32'd11, 17'd131071});
      // one set, tag is the whole address, ways above range, no penalty
      add_csr(CSR_OFFSET_BITS, 16'h0000);
      add_csr(CSR_SET_BITS, 16'h0000);
      add_csr(CSR_WAYS_IN_USE, 16'h0009);
      add_csr(CSR_MISS_PENALTY, 16'h0000);
      add_access(1'b1, 32'h0000_0004);
      add_access(1'b0, 32'h0000_0001);   // stale line from the first setting hits
      add_access(1'b0, 32'h0000_0005);
      add_access(1'b0, 32'h0000_0006);
      add_access(1'b0, 32'h0000_0007);
      add_access(1'b1, 32'hFFFF_FFFF);
      add_access(1'b0, 32'h0000_0008);
      add_access(1'b0, 32'h0000_0006);
      // exact upper limits
      add_csr(CSR_OFFSET_BITS, 16'd16);
      add_csr(CSR_SET_BITS, 16'd10);
      add_csr(CSR_WAYS_IN_USE, 16'd8);
      add_csr(CSR_MISS_PENALTY, 16'd1);
      add_access(1'b0, 32'h0001_0000);
      add_access(1'b1, 32'hFFFF_FFFF);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed part
      in_csr = 1'b0;
      foreach (dir_rows[i]) begin
         row = dir_rows[i];
         if (row.is_csr) begin
            if (!in_csr) begin
               wait_drained();
               n_settings++;
            end
            csr_write(row.csr_idx, row.csr_val);
            in_csr = 1'b1;
         end else begin
            if (in_csr) csr_we <= 1'b0;
            in_csr = 1'b0;
            send_access(row.beat, row.typed, row.want);
            maybe_idle(25);
         end
      end

      // random phases, each under fresh register settings
      for (ph = 0; ph < N_PHASES; ph++) begin
         wait_drained();
         wd = 16'($urandom);
         case ($urandom_range(4))
            0: wd[4:0] = 5'd0;
            1: wd[4:0] = 5'd16;
            2: wd[4:0] = 5'($urandom_range(17, 31));
            3: wd[4:0] = 5'($urandom_range(2, 8));
            default: wd[4:0] = 5'($urandom);
         endcase
         csr_write(CSR_OFFSET_BITS, wd);
         wd = 16'($urandom);
         case ($urandom_range(4))
            0: wd[3:0] = 4'd0;
            1: wd[3:0] = 4'd10;
            2: wd[3:0] = 4'($urandom_range(11, 15));
            3: wd[3:0] = 4'($urandom_range(1, 4));
            default: wd[3:0] = 4'($urandom);
         endcase
         csr_write(CSR_SET_BITS, wd);
         wd = 16'($urandom);
         case ($urandom_range(4))
            0: wd[3:0] = 4'd0;
            1: wd[3:0] = 4'd1;
            2: wd[3:0] = 4'd8;
            3: wd[3:0] = 4'($urandom_range(9, 15));
            default: wd[3:0] = 4'($urandom_range(2, 7));
         endcase
         csr_write(CSR_WAYS_IN_USE, wd);
         case ($urandom_range(3))
            0: wd = 16'd0;
            1: wd = 16'hFFFF;
            default: wd = 16'($urandom);
         endcase
         csr_write(CSR_MISS_PENALTY, wd);
         csr_we <= 1'b0;
         n_settings++;

         // small pools of sets and tags keep the ways contended
         eff_cfg(ob, sb, nw);
         n_sets = $urandom_range(1, 4);
         n_tags = nw + $urandom_range(1, 3);
         for (i = 0; i < n_sets; i++) begin
            rnd = $urandom & ((32'd1 << sb) - 32'd1);
            pool_set[i] = rnd[9:0];
         end
         for (i = 0; i < n_tags; i++)
            pool_tag[i] = $urandom_range(1) ? i : $urandom;

         // no idling in the last phase
         if (ph == N_PHASES - 1) idle_pct = 0;
         else case ($urandom_range(2))
            0: idle_pct = 0;
            1: idle_pct = 15;
            default: idle_pct = 40;
         endcase
         rsp_idle_pct <= idle_pct;

         for (i = 0; i < PHASE_ACCESSES; i++) begin
            beat.is_write = 1'($urandom_range(1));
            if ($urandom_range(99) < 12) begin
               beat.address = $urandom;
            end else begin
               rnd = $urandom;
               wide = ({32'd0, pool_tag[$urandom_range(n_tags - 1)]} << (ob + sb))
                    | ({54'd0, pool_set[$urandom_range(n_sets - 1)]} << ob)
                    | ({32'd0, rnd} & ((64'd1 << ob) - 64'd1));
               beat.address = wide[31:0];
            end
            send_access(beat, 1'b0, '0);
            maybe_idle(idle_pct);
         end
      end

      // wrap-up
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (owed_rsp.size() != 0)
         report_mismatch($sformatf("%0d responses never arrived", owed_rsp.size()));
      $display("covered %0d accesses (%0d directed rows) under %0d register settings",
               req_beats, dir_rows.size(), n_settings);
      $display("outcomes seen: %0d hits, %0d clean misses, %0d dirty misses; %0d errors",
               outcome_tally[0], outcome_tally[1], outcome_tally[2], n_errors);
      if (n_errors == 0) begin
         $display("set_assoc_cache_lru_model: match");
      end else begin
         $display("set_assoc_cache_lru_model: mismatch");
      end
      $finish;
   end

endmodule
